[src/gbpg_pkg.sv]
// Shared types, constants and colour helper functions for the gradient
// background pixel generator. No dependencies.
package gbpg_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = 13;
    localparam int COORD_W     = 12;
    localparam int COLOUR_W    = 24;
    localparam int STEP_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // reciprocals are floor(2^RECIP_SHIFT / d)
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int NUM_W       = 20;
    localparam int QUO_W       = 21;
    localparam int REM_W       = 14;
    localparam int N_DIV       = 5;
    localparam int N_LANE      = 6;
    localparam int N_STG       = 11;

    // division lanes
    localparam int L_GRAD = 0;
    localparam int L_LY   = 1;
    localparam int L_LX   = 2;
    localparam int L_SCAN = 3;
    localparam int L_GY   = 4;
    localparam int L_GX   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_TOP_COLOUR    = 3'd2,
        CFG_BOTTOM_COLOUR = 3'd3,
        CFG_ACCENT_COLOUR = 3'd4,
        CFG_SCANLINE_STEP = 3'd5,
        CFG_GRID_STEP     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DV_HM1  = 3'd0,
        DV_H    = 3'd1,
        DV_W    = 3'd2,
        DV_SCAN = 3'd3,
        DV_GS   = 3'd4
    } t_div_sel;

    localparam logic [7:0] GRID_ALPHA = 8'd20;

    // |b - a| * alpha
    function automatic logic [15:0] f_mag_prod(logic [7:0] a, logic [7:0] b,
                                               logic [7:0] alpha);
        logic [7:0] diff;
        diff = (a >= b) ? (a - b) : (b - a);
        return {8'd0, diff} * {8'd0, alpha};
    endfunction

    // a + sign(b - a) * (prod / 255), exact for prod up to 255 * 255
    function automatic logic [7:0] f_blend(logic [7:0] a, logic [7:0] b,
                                           logic [15:0] prod);
        logic [16:0] t;
        logic [7:0]  q;
        t = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
        q = t[15:8];
        return (b >= a) ? (a + q) : (a - q);
    endfunction

    // c * 92 / 100 = c * 23 / 25
    function automatic logic [7:0] f_darken(logic [7:0] c);
        logic [12:0] m;
        logic [28:0] p;
        m = ({5'd0, c} << 4) + ({5'd0, c} << 2) + ({5'd0, c} << 1) + {5'd0, c};
        p = {16'd0, m} * 29'd41944;
        return p[27:20];
    endfunction

endpackage

[src/gradient_background_pixel_generator_top.sv]
// Top level of the gradient background pixel generator: an 11-stage pipeline
// plus a bit-serial reciprocal unit. Depends on gbpg_pkg.
//
// Usage:
//  - Input channel (i_valid / o_ready) carries one pixel request: i_pixel_x,
//    i_pixel_y. Output channel (o_valid / i_ready) returns o_colour, 0xRRGGBB.
//  - Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is
//    high; only while no request is in flight. Unknown indexes are ignored.
//  - Throughput: one request per cycle while the output is not stalled and no
//    reciprocal pass runs. A request passes through every pipeline stage
//    before o_valid rises; the depth is set by the division lanes and the
//    three blends.
//  - All divisions by canvas size and step values use reciprocals held in
//    registers. After reset and after every configuration write the serial
//    reciprocal unit recomputes all five, one after another; o_ready stays
//    low until the pass has finished.
//  - Reset (synchronous, active low) loads the default registers, empties
//    the pipeline and starts the reciprocal pass.
//  - A stall on the output holds the last stage; each stage takes new data
//    only when it is empty or its successor moves, so bubbles fill up and
//    no request is lost or repeated.
module gradient_background_pixel_generator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [gbpg_pkg::COORD_W-1:0]       i_pixel_x,
    input  logic [gbpg_pkg::COORD_W-1:0]       i_pixel_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [gbpg_pkg::COLOUR_W-1:0]      o_colour,
    input  logic                               i_cfg_we,
    input  logic [gbpg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gbpg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gbpg_pkg::*;

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0]    r_w, r_h;
    logic [COLOUR_W-1:0] r_top, r_bot, r_acc;
    logic [STEP_W-1:0]   r_scan, r_gs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= 13'd640;
            r_h    <= 13'd480;
            r_top  <= '0;
            r_bot  <= '0;
            r_acc  <= '0;
            r_scan <= 8'd2;
            r_gs   <= 8'd32;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:   r_w    <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:  r_h    <= i_cfg_data[DIM_W-1:0];
                CFG_TOP_COLOUR:    r_top  <= i_cfg_data;
                CFG_BOTTOM_COLOUR: r_bot  <= i_cfg_data;
                CFG_ACCENT_COLOUR: r_acc  <= i_cfg_data;
                CFG_SCANLINE_STEP: r_scan <= i_cfg_data[STEP_W-1:0];
                CFG_GRID_STEP:     r_gs   <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated dimensions and effective divisors
    logic [DIM_W-1:0] w_hc, w_wc;
    logic             w_hgt1;
    logic [DIM_W-1:0] w_div [N_DIV];

    always_comb begin
        w_hc   = (r_h > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_h;
        w_wc   = (r_w > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_w;
        w_hgt1 = (w_hc > 13'd1);
        w_div[DV_HM1]  = w_hgt1 ? (w_hc - 13'd1) : 13'd1;
        w_div[DV_H]    = w_hgt1 ? w_hc : 13'd1;
        w_div[DV_W]    = (w_wc == '0) ? 13'd1 : w_wc;
        w_div[DV_SCAN] = (r_scan == '0) ? 13'd1 : {5'd0, r_scan};
        w_div[DV_GS]   = (r_gs == '0) ? 13'd1 : {5'd0, r_gs};
    end

    // ---------------- serial reciprocal unit ----------------
    // Restoring division of 2^21 by each divisor, one quotient bit a cycle.
    logic               r_busy;
    t_div_sel           r_dsel, n_dsel;
    logic [4:0]         r_bit;
    logic [DIM_W-1:0]   r_rem;
    logic [RECIP_W-1:0] r_quo;
    logic [RECIP_W-1:0] r_recip [N_DIV];

    logic [DIM_W:0]     w_rem2;
    logic               w_ge;
    logic [DIM_W-1:0]   w_rem_nx;
    logic [RECIP_W-1:0] w_quo_nx;

    always_comb begin
        w_rem2   = {r_rem, (r_bit == 5'(RECIP_SHIFT))};
        w_ge     = (w_rem2 >= {1'b0, w_div[r_dsel]});
        w_rem_nx = w_ge ? DIM_W'(w_rem2 - {1'b0, w_div[r_dsel]}) : w_rem2[DIM_W-1:0];
        w_quo_nx = {r_quo[RECIP_W-2:0], w_ge};
        unique case (r_dsel)
            DV_HM1:  n_dsel = DV_H;
            DV_H:    n_dsel = DV_W;
            DV_W:    n_dsel = DV_SCAN;
            DV_SCAN: n_dsel = DV_GS;
            default: n_dsel = DV_HM1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_busy <= 1'b1;
            r_dsel <= DV_HM1;
            r_bit  <= 5'(RECIP_SHIFT);
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            if (r_bit == 5'd0) begin
                r_rem <= '0;
                r_quo <= '0;
                r_bit <= 5'(RECIP_SHIFT);
                r_dsel <= n_dsel;
                if (r_dsel == DV_GS) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_rem <= w_rem_nx;
                r_quo <= w_quo_nx;
                r_bit <= r_bit - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && r_bit == 5'd0) begin
            r_recip[r_dsel] <= w_quo_nx;
        end
    end

    // lane -> reciprocal and divisor
    logic [RECIP_W-1:0] w_lr [N_LANE];
    logic [DIM_W-1:0]   w_ld [N_LANE];

    always_comb begin
        w_lr[L_GRAD] = r_recip[DV_HM1];  w_ld[L_GRAD] = w_div[DV_HM1];
        w_lr[L_LY]   = r_recip[DV_H];    w_ld[L_LY]   = w_div[DV_H];
        w_lr[L_LX]   = r_recip[DV_W];    w_ld[L_LX]   = w_div[DV_W];
        w_lr[L_SCAN] = r_recip[DV_SCAN]; w_ld[L_SCAN] = w_div[DV_SCAN];
        w_lr[L_GY]   = r_recip[DV_GS];   w_ld[L_GY]   = w_div[DV_GS];
        w_lr[L_GX]   = r_recip[DV_GS];   w_ld[L_GX]   = w_div[DV_GS];
    end

    // ---------------- pipeline flow control ----------------
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] w_en;

    always_comb begin
        w_en[N_STG-1] = ~r_vld[N_STG-1] | i_ready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    assign o_ready = w_en[0] & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid & o_ready;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: numerators ----------------
    logic [NUM_W-1:0] r_s0_n [N_LANE];
    logic             r_s0_nz;
    logic [NUM_W-1:0] w_n [N_LANE];
    logic [DIM_W:0]   w_dx;
    logic [DIM_W-1:0] w_adx;

    always_comb begin
        w_dx  = {1'b0, i_pixel_x, 1'b0} - {1'b0, w_wc};
        w_adx = w_dx[DIM_W] ? DIM_W'(-w_dx) : w_dx[DIM_W-1:0];
        w_n[L_GRAD] = ({8'd0, i_pixel_y} << 8) - {8'd0, i_pixel_y};
        w_n[L_LY]   = {8'd0, i_pixel_y} << 7;
        w_n[L_LX]   = {w_adx[DIM_W-1:0], 7'd0};
        w_n[L_SCAN] = {8'd0, i_pixel_y};
        w_n[L_GY]   = {8'd0, i_pixel_y};
        w_n[L_GX]   = {8'd0, i_pixel_x};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_n  <= w_n;
            r_s0_nz <= (i_pixel_x != '0) && (i_pixel_y != '0);
        end
    end

    // ---------------- stage 1: estimated quotients ----------------
    logic [NUM_W-1:0] r_s1_n [N_LANE];
    logic [QUO_W-1:0] r_s1_q [N_LANE];
    logic             r_s1_nz;
    logic [QUO_W-1:0] w_q0 [N_LANE];

    always_comb begin
        logic [NUM_W+RECIP_W-1:0] prod;
        for (int l = 0; l < N_LANE; l++) begin
            prod    = {{RECIP_W{1'b0}}, r_s0_n[l]} * {{NUM_W{1'b0}}, w_lr[l]};
            w_q0[l] = prod[RECIP_SHIFT +: QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_n  <= r_s0_n;
            r_s1_q  <= w_q0;
            r_s1_nz <= r_s0_nz;
        end
    end

    // ---------------- stage 2: remainders ----------------
    logic [QUO_W-1:0] r_s2_q [N_LANE];
    logic [REM_W-1:0] r_s2_r [N_LANE];
    logic             r_s2_nz;
    logic [REM_W-1:0] w_r0 [N_LANE];

    always_comb begin
        logic [QUO_W+DIM_W-1:0] qd;
        logic [QUO_W+DIM_W-1:0] diff;
        for (int l = 0; l < N_LANE; l++) begin
            qd      = {{DIM_W{1'b0}}, r_s1_q[l]} * {{QUO_W{1'b0}}, w_ld[l]};
            diff    = {{(QUO_W+DIM_W-NUM_W){1'b0}}, r_s1_n[l]} - qd;
            w_r0[l] = diff[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_q  <= r_s1_q;
            r_s2_r  <= w_r0;
            r_s2_nz <= r_s1_nz;
        end
    end

    // ---------------- stage 3: correction and decode ----------------
    logic [7:0] r_s3_galpha;
    logic [6:0] r_s3_lx;
    logic [5:0] r_s3_ly;
    logic       r_s3_glow, r_s3_scan, r_s3_grid;

    logic [QUO_W-1:0] w_q [N_LANE];
    logic [REM_W-1:0] w_r [N_LANE];

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            if (r_s2_r[l] >= {1'b0, w_ld[l]}) begin
                w_q[l] = r_s2_q[l] + QUO_W'(1);
                w_r[l] = r_s2_r[l] - {1'b0, w_ld[l]};
            end else begin
                w_q[l] = r_s2_q[l];
                w_r[l] = r_s2_r[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            if (!w_hgt1) begin
                r_s3_galpha <= 8'd0;
            end else if (w_q[L_GRAD] >= QUO_W'(255)) begin
                r_s3_galpha <= 8'd255;
            end else begin
                r_s3_galpha <= w_q[L_GRAD][7:0];
            end
            r_s3_lx   <= w_q[L_LX][6:0];
            r_s3_ly   <= w_hgt1 ? w_q[L_LY][5:0] : 6'd0;
            r_s3_glow <= (w_q[L_LX] < QUO_W'(128))
                         && (!w_hgt1 || w_q[L_LY] < QUO_W'(64));
            r_s3_scan <= (w_r[L_SCAN] == '0);
            r_s3_grid <= (r_gs != '0) && r_s2_nz
                         && (w_r[L_GY] == '0) && (w_r[L_GX] == '0);
        end
    end

    // ---------------- stage 4: gradient products, glow squares ----------------
    logic [15:0] r_s4_prod [3];
    logic [13:0] r_s4_lx2;
    logic [11:0] r_s4_ly2;
    logic        r_s4_glow, r_s4_scan, r_s4_grid;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int c = 0; c < 3; c++) begin
                r_s4_prod[c] <= f_mag_prod(r_top[8*c +: 8], r_bot[8*c +: 8], r_s3_galpha);
            end
            r_s4_lx2  <= {7'd0, r_s3_lx} * {7'd0, r_s3_lx};
            r_s4_ly2  <= {6'd0, r_s3_ly} * {6'd0, r_s3_ly};
            r_s4_glow <= r_s3_glow;
            r_s4_scan <= r_s3_scan;
            r_s4_grid <= r_s3_grid;
        end
    end

    // ---------------- stage 5: gradient colour, glow alpha ----------------
    logic [COLOUR_W-1:0] r_s5_c;
    logic [7:0]          r_s5_ga;
    logic                r_s5_scan, r_s5_grid;
    logic [14:0]         w_sum;
    logic [7:0]          w_lift;
    logic [10:0]         w_lift12;

    always_comb begin
        w_sum    = {1'b0, r_s4_lx2} + {1'b0, r_s4_ly2, 2'b00};
        w_lift   = 8'd128 - w_sum[14:7];
        w_lift12 = {3'd0, w_lift} * 11'd12;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int c = 0; c < 3; c++) begin
                r_s5_c[8*c +: 8] <= f_blend(r_top[8*c +: 8], r_bot[8*c +: 8],
                                            r_s4_prod[c]);
            end
            r_s5_ga   <= (r_s4_glow && w_sum[14:7] < 8'd128)
                         ? {4'd0, w_lift12[10:7]} : 8'd0;
            r_s5_scan <= r_s4_scan;
            r_s5_grid <= r_s4_grid;
        end
    end

    // ---------------- stage 6: scanline darkening ----------------
    logic [COLOUR_W-1:0] r_s6_c;
    logic [7:0]          r_s6_ga;
    logic                r_s6_grid;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int c = 0; c < 3; c++) begin
                r_s6_c[8*c +: 8] <= r_s5_scan ? f_darken(r_s5_c[8*c +: 8])
                                              : r_s5_c[8*c +: 8];
            end
            r_s6_ga   <= r_s5_ga;
            r_s6_grid <= r_s5_grid;
        end
    end

    // ---------------- stages 7-8: glow blend ----------------
    logic [15:0]         r_s7_prod [3];
    logic [COLOUR_W-1:0] r_s7_c;
    logic                r_s7_grid;
    logic [COLOUR_W-1:0] r_s8_c;
    logic                r_s8_grid;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            for (int c = 0; c < 3; c++) begin
                r_s7_prod[c] <= f_mag_prod(r_s6_c[8*c +: 8], r_acc[8*c +: 8], r_s6_ga);
            end
            r_s7_c    <= r_s6_c;
            r_s7_grid <= r_s6_grid;
        end
        if (w_en[8]) begin
            for (int c = 0; c < 3; c++) begin
                r_s8_c[8*c +: 8] <= f_blend(r_s7_c[8*c +: 8], r_acc[8*c +: 8],
                                            r_s7_prod[c]);
            end
            r_s8_grid <= r_s7_grid;
        end
    end

    // ---------------- stages 9-10: grid blend ----------------
    logic [15:0]         r_s9_prod [3];
    logic [COLOUR_W-1:0] r_s9_c;
    logic [COLOUR_W-1:0] r_s10_c;

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            for (int c = 0; c < 3; c++) begin
                r_s9_prod[c] <= f_mag_prod(r_s8_c[8*c +: 8], r_acc[8*c +: 8],
                                           r_s8_grid ? GRID_ALPHA : 8'd0);
            end
            r_s9_c <= r_s8_c;
        end
        if (w_en[10]) begin
            for (int c = 0; c < 3; c++) begin
                r_s10_c[8*c +: 8] <= f_blend(r_s9_c[8*c +: 8], r_acc[8*c +: 8],
                                             r_s9_prod[c]);
            end
        end
    end

    assign o_valid  = r_vld[N_STG-1];
    assign o_colour = r_s10_c;

`ifndef SYNTHESIS
    // no request is taken while reciprocals are being rebuilt
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready) else $error("request accepted during reciprocal pass");

    // a configuration write always restarts the reciprocal pass
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_busy) else $error("config write did not restart pass");

    // step reciprocal is at least 2^21/255 once the pass has finished
    a_recip_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_recip[DV_SCAN] >= RECIP_W'(8224)))
        else $error("scanline reciprocal out of range");
`endif

endmodule

[bench/tb.sv]
// Self-checking bench for gradient_background_pixel_generator_top: a colour
// predictor, random stalls on both channels. Depends on gbpg_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
    import gbpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [COORD_W-1:0]    i_pixel_x;
    logic [COORD_W-1:0]    i_pixel_y;
    logic                  o_valid;
    logic                  i_ready;
    logic [COLOUR_W-1:0]   o_colour;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gradient_background_pixel_generator_top dut (.*);

    // bench copy of the register file
    logic [DIM_W-1:0]    canvas_w, canvas_h;
    logic [COLOUR_W-1:0] top_col, bottom_col, accent_col;
    logic [STEP_W-1:0]   scan_step, grid_pitch;

    logic [COLOUR_W-1:0] colour_q[$];
    int                  errors;
    int                  quiet_cycles;
    bit                  no_idle;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] clamp8(longint v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic logic [23:0] blend_toward(logic [23:0] a, logic [23:0] b,
                                                 longint alpha);
        logic [23:0] r;
        longint      ca, cb;
        if (alpha <= 0) return a;
        if (alpha >= 255) return b;
        for (int i = 0; i < 3; i++) begin
            ca = a[8*i +: 8];
            cb = b[8*i +: 8];
            r[8*i +: 8] = clamp8(ca + (cb - ca) * alpha / 255);
        end
        return r;
    endfunction

    function automatic logic [23:0] dim_scanline(logic [23:0] c);
        logic [23:0] r;
        longint      v;
        for (int i = 0; i < 3; i++) begin
            v = c[8*i +: 8];
            r[8*i +: 8] = clamp8(v * 92 / 100);
        end
        return r;
    endfunction

    function automatic logic [23:0] pixel_colour(logic [11:0] px, logic [11:0] py);
        longint      x, y, w, h, sc, gs, lx, ly, lift;
        logic [23:0] c;
        x  = px;
        y  = py;
        w  = (canvas_w > MAX_DIM) ? MAX_DIM : canvas_w;
        h  = (canvas_h > MAX_DIM) ? MAX_DIM : canvas_h;
        sc = (scan_step != 0) ? scan_step : 1;
        gs = grid_pitch;
        c = blend_toward(top_col, bottom_col, (h > 1) ? y * 255 / (h - 1) : 0);
        if (y % sc == 0) c = dim_scanline(c);
        ly   = (h > 1) ? y * 128 / h : 0;
        lx   = (2 * x - w) * 128 / ((w > 0) ? w : 1);
        lift = 128 - (lx * lx + ly * ly * 4) / 128;
        if (lift > 0) c = blend_toward(c, accent_col, lift * 12 / 128);
        if (gs > 0 && y > 0 && x > 0 && y % gs == 0 && x % gs == 0)
            c = blend_toward(c, accent_col, GRID_ALPHA);
        return c;
    endfunction

    // mostly short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sink side: random back-pressure
    initial begin
        int g;
        i_ready = 1'b0;
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            g = pick_gap();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // result checker: compare each accepted colour with the oldest expectation
    always @(posedge i_clk) begin
        logic [23:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (colour_q.size() == 0) begin
                $display("%0t: unexpected colour, expected none, actual %06h",
                         $time, o_colour);
                errors++;
            end else begin
                want = colour_q.pop_front();
                if (o_colour !== want) begin
                    $display("%0t: colour mismatch, expected %06h, actual %06h",
                             $time, want, o_colour);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** gradient_background_pixel_generator_top: FAILED **");
            $finish;
        end
    end

    // one pixel request; valid stays up into the next request when no gap follows
    task automatic send_pixel(logic [11:0] x, logic [11:0] y);
        int g;
        i_valid   <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        do @(posedge i_clk); while (!o_ready);
        colour_q.push_back(pixel_colour(x, y));
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (colour_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one write, then a cycle with the enable low
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (t_cfg_idx'(idx))
            CFG_IMAGE_WIDTH:   canvas_w   = data[DIM_W-1:0];
            CFG_IMAGE_HEIGHT:  canvas_h   = data[DIM_W-1:0];
            CFG_TOP_COLOUR:    top_col    = data;
            CFG_BOTTOM_COLOUR: bottom_col = data;
            CFG_ACCENT_COLOUR: accent_col = data;
            CFG_SCANLINE_STEP: scan_step  = data[STEP_W-1:0];
            CFG_GRID_STEP:     grid_pitch = data[STEP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 24'($urandom_range(0, 1));
        if (r < 16) return 24'($urandom_range(4096, 8191));
        if (r < 60) return 24'($urandom_range(2, 64));
        return 24'($urandom_range(2, 4096));
    endfunction

    function automatic logic [23:0] rand_step();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'd0;
        if (r == 1) return 24'd1;
        if (r == 2) return 24'd255;
        return 24'($urandom_range(1, 40));
    endfunction

    task automatic rand_config();
        cfg_write(CFG_IMAGE_WIDTH, rand_dim());
        cfg_write(CFG_IMAGE_HEIGHT, rand_dim());
        cfg_write(CFG_TOP_COLOUR, 24'($urandom()));
        cfg_write(CFG_BOTTOM_COLOUR, 24'($urandom()));
        cfg_write(CFG_ACCENT_COLOUR,
                  ($urandom_range(0, 7) == 0) ? 24'hffffff : 24'($urandom()));
        cfg_write(CFG_SCANLINE_STEP, rand_step());
        cfg_write(CFG_GRID_STEP, rand_step());
        if ($urandom_range(0, 3) == 0) cfg_write(CFG_IDX_UNUSED, 24'($urandom()));
    endtask

    // coordinate picked near grid points, inside the canvas, or anywhere
    function automatic logic [11:0] rand_coord(logic [12:0] dim);
        int r, d, k;
        r = $urandom_range(0, 99);
        d = (dim == 0) ? 1 : ((dim > MAX_DIM) ? MAX_DIM : dim);
        if (r < 30 && grid_pitch != 0) begin
            k = $urandom_range(0, (d - 1) / grid_pitch);
            return 12'(k * grid_pitch);
        end
        if (r < 85) return 12'($urandom_range(0, d - 1));
        return 12'($urandom());
    endfunction

    task automatic test_reset_defaults();
        send_pixel(0, 0);
        send_pixel(320, 240);
        send_pixel(32, 64);
        send_pixel(639, 479);
        wait_idle();
    endtask

    task automatic test_extremes();
        cfg_write(CFG_TOP_COLOUR, 24'hffffff);
        cfg_write(CFG_BOTTOM_COLOUR, 24'h000000);
        cfg_write(CFG_ACCENT_COLOUR, 24'h00ff80);
        cfg_write(CFG_SCANLINE_STEP, 24'd255);
        cfg_write(CFG_GRID_STEP, 24'd1);
        send_pixel(0, 0);
        send_pixel(12'hfff, 12'hfff);
        send_pixel(12'hfff, 0);
        send_pixel(0, 12'hfff);
        send_pixel(12'haaa, 12'h555);
        send_pixel(12'h555, 12'haaa);
        wait_idle();
    endtask

    task automatic test_special_cases();
        // zero width, unit height, zero scanline step, zero grid step
        cfg_write(CFG_IMAGE_WIDTH, 24'd0);
        cfg_write(CFG_IMAGE_HEIGHT, 24'd1);
        cfg_write(CFG_SCANLINE_STEP, 24'd0);
        cfg_write(CFG_GRID_STEP, 24'd0);
        send_pixel(0, 0);
        send_pixel(7, 3);
        send_pixel(12'hfff, 12'hfff);
        wait_idle();
        // oversize width saturates; zero height; unknown index ignored
        cfg_write(CFG_IMAGE_WIDTH, 24'h1fff);
        cfg_write(CFG_IMAGE_HEIGHT, 24'd0);
        cfg_write(CFG_IDX_UNUSED, 24'hffffff);
        cfg_write(CFG_GRID_STEP, 24'd255);
        send_pixel(2048, 0);
        send_pixel(255, 255);
        send_pixel(510, 765);
        wait_idle();
        // coordinates outside a small canvas: gradient alpha past full scale
        cfg_write(CFG_IMAGE_WIDTH, 24'd4);
        cfg_write(CFG_IMAGE_HEIGHT, 24'd4096);
        cfg_write(CFG_BOTTOM_COLOUR, 24'h123456);
        send_pixel(2, 2);
        send_pixel(100, 4095);
        wait_idle();
        cfg_write(CFG_IMAGE_HEIGHT, 24'd3);
        send_pixel(1, 2);
        send_pixel(3000, 200);
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 12; p++) begin
            rand_config();
            no_idle = (p % 4 == 3);
            repeat (150) send_pixel(rand_coord(canvas_w), rand_coord(canvas_h));
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    // sender holds off until the pipeline has drained, then resumes
    task automatic test_drain_pause();
        repeat (25) send_pixel(rand_coord(canvas_w), rand_coord(canvas_h));
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (colour_q.size() != 0) @(posedge i_clk);
        repeat (25) send_pixel(rand_coord(canvas_w), rand_coord(canvas_h));
        wait_idle();
    endtask

    initial begin
        errors     = 0;
        no_idle    = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_pixel_x  = '0;
        i_pixel_y  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        canvas_w   = 13'd640;
        canvas_h   = 13'd480;
        top_col    = '0;
        bottom_col = '0;
        accent_col = '0;
        scan_step  = 8'd2;
        grid_pitch = 8'd32;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_special_cases();
        test_random_phases();
        test_drain_pause();

        if (errors == 0)
            $display("** gradient_background_pixel_generator_top: PASSED **");
        else
            $display("** gradient_background_pixel_generator_top: FAILED **");
        $finish;
    end

endmodule

[gradient_background_pixel_generator_top.f]
src/gbpg_pkg.sv
src/gradient_background_pixel_generator_top.sv
bench/tb.sv
